// ===== rtl/pen_line_rasterizer_core_defines.svh =====
// ----------------------------------------------------------------------------
// pen line rasterizer assertion macros
// shared concurrent check macros, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef PEN_LINE_RASTERIZER_CORE_DEFINES_SVH
`define PEN_LINE_RASTERIZER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PLR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plr check failed");
// next-cycle implication
`define PLR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plr check failed");
`else
`define PLR_ASSERT_IMP(label, clk, rst, ante, cons)
`define PLR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// plr_pkg
// shared types and constants of the pen line rasterizer
// ----------------------------------------------------------------------------
package plr_pkg;

  localparam int COORD_W   = 6;
  localparam int GRID_W    = 7;
  localparam int ERR_W     = 8;
  localparam int GRID_MAX  = 64;
  localparam int WALK_LAST = 63;

  localparam logic FUNC_MOVE = 1'b0;
  localparam logic FUNC_LINE = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAW
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic done;
  } dp_sts_t;

endpackage

// ===== rtl/plr_channels.sv =====
// ----------------------------------------------------------------------------
// plr channels
// valid/ready channel interfaces for pen commands and plotted pixels
// ----------------------------------------------------------------------------
interface plr_cmd_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [plr_pkg::COORD_W-1:0] target_x;
  logic [plr_pkg::COORD_W-1:0] target_y;

  modport source (output valid, output func, output target_x, output target_y,
                  input ready);
  modport sink (input valid, input func, input target_x, input target_y,
                output ready);
endinterface

interface plr_pix_if;
  logic                     valid;
  logic                     ready;
  logic [plr_pkg::COORD_W-1:0] pixel_x;
  logic [plr_pkg::COORD_W-1:0] pixel_y;
  logic                     in_grid;
  logic                     last;

  modport source (output valid, output pixel_x, output pixel_y, output in_grid,
                  output last, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input in_grid,
                input last, output ready);
endinterface

// ===== rtl/pen_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// pen_line_rasterizer_core
// pen plotter line engine: bresenham walk from the pen to each line target
// ----------------------------------------------------------------------------
// A move command is taken and only repositions the pen. A line command is
// taken, then the walk emits one pixel per cycle into the output register
// while that register is free (a stall on the pixel channel holds the walk),
// both end points included, at most 64 pixels per line. While a line
// is being walked no new command is taken. The last pixel carries last = 1,
// and in_grid flags pixels inside the configured square grid (grid_size,
// limited to 64; zero after reset, so every pixel is outside until written).

module pen_line_rasterizer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        grid_we,
  input  logic [plr_pkg::GRID_W-1:0]  grid_wdata,
  plr_cmd_if.sink                     cmd,
  plr_pix_if.source                   pixel
);
  import plr_pkg::*;

  ctrl_cmd_t ctl;
  dp_sts_t   sts;
  logic      ready;

  assign cmd.ready = ready;

  plr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_func  (cmd.func),
    .in_ready (ready),
    .cmd      (ctl),
    .sts      (sts)
  );

  plr_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl),
    .sts         (sts),
    .grid_we     (grid_we),
    .grid_wdata  (grid_wdata),
    .target_x    (cmd.target_x),
    .target_y    (cmd.target_y),
    .out_valid   (pixel.valid),
    .out_ready   (pixel.ready),
    .out_x       (pixel.pixel_x),
    .out_y       (pixel.pixel_y),
    .out_in_grid (pixel.in_grid),
    .out_last    (pixel.last)
  );

endmodule

// ===== rtl/plr_dpath.sv =====
// ----------------------------------------------------------------------------
// plr_dpath
// pen position, line walk registers, error term and pixel output register
// ----------------------------------------------------------------------------
module plr_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  plr_pkg::ctrl_cmd_t           cmd,
  output plr_pkg::dp_sts_t             sts,
  input  logic                         grid_we,
  input  logic [plr_pkg::GRID_W-1:0]   grid_wdata,
  input  logic [plr_pkg::COORD_W-1:0]  target_x,
  input  logic [plr_pkg::COORD_W-1:0]  target_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [plr_pkg::COORD_W-1:0]  out_x,
  output logic [plr_pkg::COORD_W-1:0]  out_y,
  output logic                         out_in_grid,
  output logic                         out_last
);
  import plr_pkg::*;

  logic [GRID_W-1:0]  grid_size;
  coord_t             pen_x;
  coord_t             pen_y;
  coord_t             walk_x;
  coord_t             walk_y;
  coord_t             tgt_x;
  coord_t             tgt_y;
  coord_t             dx;
  coord_t             dy;
  logic               sx;
  logic               sy;
  logic [ERR_W-1:0]   error_term;
  coord_t             count;

  coord_t             dx_next;
  coord_t             dy_next;
  logic [ERR_W-1:0]   err_init;
  logic [ERR_W:0]     e2;
  logic [ERR_W:0]     dx_ext;
  logic [ERR_W:0]     dy_ext;
  logic [ERR_W:0]     err_next;
  logic               move_x;
  logic               move_y;
  logic [GRID_W-1:0]  grid_lim;
  logic               in_range;
  logic               done;

  always_comb begin
    dx_next  = (pen_x < target_x) ? (target_x - pen_x) : (pen_x - target_x);
    dy_next  = (pen_y < target_y) ? (target_y - pen_y) : (pen_y - target_y);
    // halving truncates toward zero, so the negative case negates after the shift
    if (dx_next > dy_next) begin
      err_init = ERR_W'(dx_next >> 1);
    end else begin
      err_init = ERR_W'(0) - ERR_W'(dy_next >> 1);
    end

    e2       = {error_term[ERR_W-1], error_term};
    dx_ext   = (ERR_W+1)'(dx);
    dy_ext   = (ERR_W+1)'(dy);
    move_x   = $signed(e2) > $signed((ERR_W+1)'(0) - dx_ext);
    move_y   = $signed(e2) < $signed(dy_ext);
    err_next = e2 - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);

    grid_lim = (grid_size > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_size;
    in_range = ({1'b0, walk_x} < grid_lim) && ({1'b0, walk_y} < grid_lim);
    done     = ((walk_x == tgt_x) && (walk_y == tgt_y)) ||
               (count == COORD_W'(WALK_LAST));
  end

  assign sts.done     = done;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= '0;
    end else if (grid_we) begin
      grid_size <= grid_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (cmd.start) begin
      pen_x <= target_x;
      pen_y <= target_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      walk_x     <= pen_x;
      walk_y     <= pen_y;
      tgt_x      <= target_x;
      tgt_y      <= target_y;
      dx         <= dx_next;
      dy         <= dy_next;
      sx         <= pen_x < target_x;
      sy         <= pen_y < target_y;
      error_term <= err_init;
      count      <= '0;
    end else if (cmd.step) begin
      if (move_x) begin
        walk_x <= sx ? (walk_x + COORD_W'(1)) : (walk_x - COORD_W'(1));
      end
      if (move_y) begin
        walk_y <= sy ? (walk_y + COORD_W'(1)) : (walk_y - COORD_W'(1));
      end
      error_term <= err_next[ERR_W-1:0];
      count      <= count + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_x       <= walk_x;
      out_y       <= walk_y;
      out_in_grid <= in_range;
      out_last    <= done;
    end
  end

endmodule

// ===== rtl/plr_ctrl.sv =====
// ----------------------------------------------------------------------------
// plr_ctrl
// sequencer: takes pen commands and paces the line walk against the output
// ----------------------------------------------------------------------------
`include "pen_line_rasterizer_core_defines.svh"

module plr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  output plr_pkg::ctrl_cmd_t  cmd,
  input  plr_pkg::dp_sts_t    sts
);
  import plr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_func == FUNC_LINE) begin
            state_next = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        // one pixel per cycle while the output register can take it
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `PLR_ASSERT_IMP(a_step_has_room, clk, rst, cmd.step, sts.out_free)
  `PLR_ASSERT_NXT(a_last_ends_walk, clk, rst, cmd.step && sts.done, state == ST_IDLE)
  `PLR_ASSERT_NXT(a_line_starts_walk, clk, rst, in_valid && in_ready && in_func, state == ST_DRAW)
  `PLR_ASSERT_IMP(a_no_start_mid_walk, clk, rst, cmd.step, !cmd.start)

endmodule

// ===== test/tb_pen_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// tb_pen_line_rasterizer_core
// Drives pen moves and line commands into the rasterizer and checks every
// plotted pixel against a behavioral Bresenham walk kept in a scoreboard.
// Both channels idle and stall in random bursts while the grid size changes
// between phases.
// ----------------------------------------------------------------------------
module tb_pen_line_rasterizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import plr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   in_grid;
    logic   last;
  } pixel_t;

  // tracks the pen and the pixels each line must produce
  class pen_tracker;
    coord_t            pen_x;
    coord_t            pen_y;
    logic [GRID_W-1:0] grid;
    pixel_t            pending_pixels[$];
    int                errors;
    int                checked;
    int                lines;
    int                moves;

    function new();
      pen_x   = '0;
      pen_y   = '0;
      grid    = '0;
      errors  = 0;
      checked = 0;
      lines   = 0;
      moves   = 0;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    task flag_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $realtime, msg);
      errors++;
    endtask

    function void take_command(input logic f, input coord_t tx, input coord_t ty);
      int     x;
      int     y;
      int     t_x;
      int     t_y;
      int     dx;
      int     dy;
      int     sx;
      int     sy;
      int     err;
      int     e2;
      int     lim;
      int     n;
      bit     done;
      pixel_t px;
      if (f == FUNC_MOVE) begin
        moves++;
        pen_x = tx;
        pen_y = ty;
        return;
      end
      lines++;
      lim = (grid > GRID_MAX) ? GRID_MAX : int'(grid);
      x   = pen_x;
      y   = pen_y;
      t_x = tx;
      t_y = ty;
      dx  = (t_x > x) ? t_x - x : x - t_x;
      dy  = (t_y > y) ? t_y - y : y - t_y;
      sx  = (x < t_x) ? 1 : -1;
      sy  = (y < t_y) ? 1 : -1;
      err = ((dx > dy) ? dx : -dy) / 2;
      n    = 0;
      done = 1'b0;
      while (!done) begin
        // the walk is cut off at its 64th pixel
        done = (x == t_x && y == t_y) || (n == WALK_LAST);
        px.x       = coord_t'(x);
        px.y       = coord_t'(y);
        px.in_grid = (x < lim) && (y < lim);
        px.last    = done;
        pending_pixels.push_back(px);
        n++;
        if (!done) begin
          e2 = err;
          if (e2 > -dx) begin
            err -= dy;
            x = (x + sx) & (GRID_MAX - 1);
          end
          if (e2 < dy) begin
            err += dx;
            y = (y + sy) & (GRID_MAX - 1);
          end
        end
      end
      pen_x = tx;
      pen_y = ty;
    endfunction

    task check_pixel(input pixel_t got);
      pixel_t exp_px;
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("pixel (%0d,%0d) with nothing pending", got.x, got.y));
        return;
      end
      exp_px = pending_pixels.pop_front();
      checked++;
      if (got.x !== exp_px.x)
        flag_mismatch($sformatf("pixel_x %0d, want %0d", got.x, exp_px.x));
      if (got.y !== exp_px.y)
        flag_mismatch($sformatf("pixel_y %0d, want %0d", got.y, exp_px.y));
      if (got.in_grid !== exp_px.in_grid)
        flag_mismatch($sformatf("in_grid %b at (%0d,%0d), want %b", got.in_grid,
                                exp_px.x, exp_px.y, exp_px.in_grid));
      if (got.last !== exp_px.last)
        flag_mismatch($sformatf("last %b at (%0d,%0d), want %b", got.last,
                                exp_px.x, exp_px.y, exp_px.last));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              grid_we;
  logic [GRID_W-1:0] grid_wdata;
  bit                quiet = 1'b0;
  int                cycles = 0;
  int                grid_writes = 0;

  pen_tracker tracker = new();

  plr_cmd_if cmd_ch ();
  plr_pix_if pix_ch ();

  pen_line_rasterizer_core DUT (
    .clk        (clk),
    .rst        (rst),
    .grid_we    (grid_we),
    .grid_wdata (grid_wdata),
    .cmd        (cmd_ch),
    .pixel      (pix_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycles,
               tracker.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // pixels of an earlier line are checked before a new command is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready)
        tracker.check_pixel({pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.in_grid,
                             pix_ch.last});
      if (cmd_ch.valid && cmd_ch.ready)
        tracker.take_command(cmd_ch.func, cmd_ch.target_x, cmd_ch.target_y);
    end
  end

  // pixel receiver with stall bursts
  initial begin : pixel_sink
    int stall_left;
    stall_left = 0;
    pix_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        pix_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(input logic f, input coord_t tx, input coord_t ty);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.func     <= f;
    cmd_ch.target_x <= tx;
    cmd_ch.target_y <= ty;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
  endtask

  // hold off commands until every pixel has been drained
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_grid(input int side);
    grid_we    <= 1'b1;
    grid_wdata <= side[GRID_W-1:0];
    tracker.grid = side[GRID_W-1:0];
    grid_writes++;
    @(posedge clk);
    grid_we <= 1'b0;
  endtask

  function automatic coord_t near_pen(input coord_t c);
    return coord_t'(int'(c) + $urandom_range(0, 6) - 3);
  endfunction

  initial begin : stimulus
    int     grids[4];
    logic   f;
    coord_t tx;
    coord_t ty;
    rst             <= 1'b1;
    grid_we         <= 1'b0;
    grid_wdata      <= '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.func     <= FUNC_MOVE;
    cmd_ch.target_x <= '0;
    cmd_ch.target_y <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // grid size still zero after reset: nothing is inside
    send_cmd(FUNC_LINE, 6'd0, 6'd0);
    send_cmd(FUNC_LINE, 6'd63, 6'd63);
    send_cmd(FUNC_LINE, 6'd0, 6'd0);
    wait_idle();

    write_grid(GRID_MAX);
    send_cmd(FUNC_LINE, 6'd63, 6'd0);
    send_cmd(FUNC_LINE, 6'd0, 6'd63);
    send_cmd(FUNC_LINE, 6'd63, 6'd63);
    send_cmd(FUNC_MOVE, 6'd10, 6'd40);
    send_cmd(FUNC_LINE, 6'd10, 6'd40);
    send_cmd(FUNC_LINE, 6'd13, 6'd2);
    send_cmd(FUNC_LINE, 6'd50, 6'd9);
    send_cmd(FUNC_LINE, 6'd0, 6'd0);
    wait_idle();

    // sizes past the maximum act as the maximum
    write_grid(127);
    send_cmd(FUNC_LINE, 6'd63, 6'd62);
    send_cmd(FUNC_MOVE, 6'd0, 6'd63);
    send_cmd(FUNC_LINE, 6'd63, 6'd0);
    wait_idle();

    write_grid(1);
    send_cmd(FUNC_LINE, 6'd1, 6'd1);
    send_cmd(FUNC_LINE, 6'd0, 6'd0);
    send_cmd(FUNC_MOVE, 6'd42, 6'd21);
    send_cmd(FUNC_LINE, 6'd21, 6'd42);
    send_cmd(FUNC_LINE, 6'd21, 6'd42);

    grids[0] = $urandom_range(2, 63);
    grids[1] = GRID_MAX;
    grids[2] = $urandom_range(65, 127);
    grids[3] = $urandom_range(0, 127);
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      write_grid(grids[phase]);
      quiet = (phase == 3);
      for (int i = 0; i < 25; i++) begin
        f = ($urandom_range(0, 4) == 0) ? FUNC_MOVE : FUNC_LINE;
        if ($urandom_range(0, 2) == 0) begin
          tx = near_pen(tracker.pen_x);
          ty = near_pen(tracker.pen_y);
        end else begin
          tx = coord_t'($urandom_range(0, 63));
          ty = coord_t'($urandom_range(0, 63));
        end
        send_cmd(f, tx, ty);
      end
    end

    cmd_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d lines and %0d pen moves, %0d pixels checked",
             tracker.lines, tracker.moves, tracker.checked);
    $display("grid size set %0d times, from empty through oversized", grid_writes);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
